@@ sv/chmc_pkg.sv @@
// shared types for the monotone chain convex hull block
// command and status structs between controller and datapath; no dependencies
`default_nettype none
package chmc_pkg;
	typedef logic signed [15:0] coord_t;

	typedef enum logic [1:0] {
		DST_A,
		DST_B,
		DST_OUT
	} rdst_t;

	typedef struct packed {
		logic  ins;
		logic  shift;
		logic  rd_s;
		logic  st_rd;
		logic  st_wr;
		rdst_t dest;
		logic  mul;
		logic  out_last;
		logic  clr;
	} cmd_t;

	typedef struct packed {
		logic rt;
		logic ovf;
	} sts_t;

	function automatic logic pt_before(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		return (ax < bx) || ((ax == bx) && (ay < by));
	endfunction
endpackage
`default_nettype wire

@@ sv/chmc_datapath.sv @@
// datapath: sorted insertion lanes, sorted point memory, hull stack memory, cross product
// depends on chmc_pkg
`default_nettype none
module chmc_datapath #(
	parameter int MAX_POINTS = 32,
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int IW = $clog2(MAX_POINTS),
	parameter int SW = $clog2(2 * MAX_POINTS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire chmc_pkg::cmd_t  cmd,
	input  wire logic [IW-1:0]   s_waddr,
	input  wire logic [IW-1:0]   s_raddr,
	input  wire logic [SW-1:0]   st_addr,
	input  wire chmc_pkg::coord_t in_x,
	input  wire chmc_pkg::coord_t in_y,
	output chmc_pkg::sts_t       sts,
	output logic [CW-1:0]        n_out,
	output chmc_pkg::coord_t     hull_x,
	output chmc_pkg::coord_t     hull_y,
	output logic                 hull_end,
	output logic                 points_dropped
);
	chmc_pkg::coord_t sx_q [MAX_POINTS];
	chmc_pkg::coord_t sy_q [MAX_POINTS];
	logic [31:0] smem_q [MAX_POINTS];
	logic [31:0] stk_q [2*MAX_POINTS];
	logic [CW-1:0] n_q, cnt_q;
	logic ovf_q;
	logic [31:0] a_q, b_q, c_q;
	logic signed [33:0] p1_q, p2_q;
	logic [MAX_POINTS-1:0] lt;
	logic eq_any;
	logic signed [16:0] dx1, dy1, dx2, dy2;

	// lane compares for insertion
	always_comb begin
		eq_any = 1'b0;
		for (int j = 0; j < MAX_POINTS; j++) begin
			if (CW'(j) < n_q) begin
				lt[j] = chmc_pkg::pt_before(in_x, in_y, sx_q[j], sy_q[j]);
				if (in_x == sx_q[j] && in_y == sy_q[j]) eq_any = 1'b1;
			end else begin
				lt[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && cnt_q < CW'(MAX_POINTS) && !eq_any) begin
			if (lt[0]) begin
				sx_q[0] <= in_x;
				sy_q[0] <= in_y;
			end
			for (int j = 1; j < MAX_POINTS; j++) begin
				if (lt[j]) begin
					if (!lt[j-1]) begin
						sx_q[j] <= in_x;
						sy_q[j] <= in_y;
					end else begin
						sx_q[j] <= sx_q[j-1];
						sy_q[j] <= sy_q[j-1];
					end
				end
			end
		end else if (cmd.shift) begin
			for (int j = 0; j < MAX_POINTS - 1; j++) begin
				sx_q[j] <= sx_q[j+1];
				sy_q[j] <= sy_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clr) begin
			n_q   <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.ins) begin
			if (cnt_q < CW'(MAX_POINTS)) begin
				cnt_q <= cnt_q + 1'b1;
				if (!eq_any) n_q <= n_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// sorted point memory
	always_ff @(posedge clk) begin
		if (cmd.shift) smem_q[s_waddr] <= {sx_q[0], sy_q[0]};
		if (cmd.rd_s) c_q <= smem_q[s_raddr];
	end

	// hull stack memory
	always_ff @(posedge clk) begin
		if (cmd.st_wr) stk_q[st_addr] <= c_q;
		if (cmd.st_rd) begin
			case (cmd.dest)
				chmc_pkg::DST_A: a_q <= stk_q[st_addr];
				chmc_pkg::DST_B: b_q <= stk_q[st_addr];
				chmc_pkg::DST_OUT: begin
					hull_x         <= stk_q[st_addr][31:16];
					hull_y         <= stk_q[st_addr][15:0];
					hull_end       <= cmd.out_last;
					points_dropped <= ovf_q;
				end
				default: a_q <= stk_q[st_addr];
			endcase
		end
	end

	// cross product terms
	always_comb begin
		dx1 = {b_q[31], b_q[31:16]} - {a_q[31], a_q[31:16]};
		dy1 = {b_q[15], b_q[15:0]} - {a_q[15], a_q[15:0]};
		dx2 = {c_q[31], c_q[31:16]} - {b_q[31], b_q[31:16]};
		dy2 = {c_q[15], c_q[15:0]} - {b_q[15], b_q[15:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1_q <= dx1 * dy2;
			p2_q <= dx2 * dy1;
		end
	end

	assign sts.rt  = p1_q < p2_q;
	assign sts.ovf = ovf_q;
	assign n_out   = n_q;
endmodule
`default_nettype wire

@@ sv/chmc_ctrl.sv @@
// controller: load, sort unload, hull chain passes with backtracking, output sequencing
// depends on chmc_pkg
`default_nettype none
module chmc_ctrl #(
	parameter int MAX_POINTS = 32,
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int IW = $clog2(MAX_POINTS),
	parameter int SW = $clog2(2 * MAX_POINTS),
	parameter int TW = $clog2(2 * MAX_POINTS + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           set_end,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire chmc_pkg::sts_t sts,
	input  wire logic [CW-1:0]  n,
	output chmc_pkg::cmd_t      cmd,
	output logic [IW-1:0]       s_waddr,
	output logic [IW-1:0]       s_raddr,
	output logic [SW-1:0]       st_addr
);
	typedef enum logic [3:0] {
		S_LOAD, S_SHIFT, S_RDC, S_CHK, S_RDA, S_MUL, S_CMP, S_PUSH, S_ORD, S_OWAIT
	} state_t;

	state_t state_q;
	logic [IW-1:0] j_q, i_q;
	logic [TW-1:0] top_q, lower_q, total_q;
	logic [SW-1:0] k_q;
	logic phase_q;
	logic chk;

	assign chk       = phase_q ? (top_q > lower_q) : (top_q >= TW'(2));
	assign in_stall  = state_q != S_LOAD;
	assign out_valid = state_q == S_OWAIT;
	assign s_waddr   = j_q;
	assign s_raddr   = i_q;

	always_comb begin
		cmd = '0;
		cmd.dest = chmc_pkg::DST_A;
		st_addr = top_q[SW-1:0];
		case (state_q)
			S_LOAD:  cmd.ins = in_valid;
			S_SHIFT: cmd.shift = 1'b1;
			S_RDC:   cmd.rd_s = 1'b1;
			S_CHK: begin
				cmd.st_rd = chk;
				cmd.dest  = chmc_pkg::DST_B;
				st_addr   = SW'(top_q - 1'b1);
			end
			S_RDA: begin
				cmd.st_rd = 1'b1;
				st_addr   = SW'(top_q - TW'(2));
			end
			S_MUL:   cmd.mul = 1'b1;
			S_PUSH:  cmd.st_wr = 1'b1;
			S_ORD: begin
				cmd.st_rd    = 1'b1;
				cmd.dest     = chmc_pkg::DST_OUT;
				cmd.out_last = TW'(k_q) == total_q - 1'b1;
				st_addr      = k_q;
			end
			S_OWAIT: cmd.clr = !out_stall && (TW'(k_q) == total_q - 1'b1);
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			j_q     <= '0;
			i_q     <= '0;
			top_q   <= '0;
			lower_q <= '0;
			total_q <= '0;
			k_q     <= '0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid && set_end) begin
						j_q     <= '0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					j_q <= j_q + 1'b1;
					if (CW'(j_q) == n - 1'b1) begin
						i_q     <= '0;
						top_q   <= '0;
						phase_q <= 1'b0;
						state_q <= S_RDC;
					end
				end
				S_RDC: state_q <= S_CHK;
				S_CHK:   state_q <= chk ? S_RDA : S_PUSH;
				S_RDA:   state_q <= S_MUL;
				S_MUL:   state_q <= S_CMP;
				S_CMP: begin
					if (sts.rt) begin
						state_q <= S_PUSH;
					end else begin
						top_q   <= top_q - 1'b1;
						state_q <= S_CHK;
					end
				end
				S_PUSH: begin
					top_q <= top_q + 1'b1;
					if (!phase_q) begin
						if (CW'(i_q) == n - 1'b1) begin
							if (n == CW'(1)) begin
								total_q <= TW'(1);
								k_q     <= '0;
								state_q <= S_ORD;
							end else begin
								lower_q <= top_q + 1'b1;
								phase_q <= 1'b1;
								i_q     <= IW'(n - CW'(2));
								state_q <= S_RDC;
							end
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RDC;
						end
					end else begin
						if (i_q == '0) begin
							total_q <= top_q;
							k_q     <= '0;
							state_q <= S_ORD;
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_RDC;
						end
					end
				end
				S_ORD: state_q <= S_OWAIT;
				S_OWAIT: begin
					if (!out_stall) begin
						if (TW'(k_q) == total_q - 1'b1) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/convex_hull_monotone_chain.sv @@
// Convex hull of a point set by the monotone chain method. Points are taken one per
// cycle while in_stall is low and inserted in sorted order (duplicates merged) into a
// row of lanes; points past MAX_POINTS are dropped and flagged. After the transaction
// with set_end, the sorted row is unloaded into a memory one distinct point at a time,
// then the upper and lower chains are built in turn on a stack memory: each point is
// read and checked against the stack; per compare, two entries are read in turn from
// the single-port stack and the cross product is registered, then a pop or a push.
// Vertices leave in clockwise order, each held in S_OWAIT while out_stall is high.
// depends on chmc_pkg, chmc_ctrl, chmc_datapath
`default_nettype none
module convex_hull_monotone_chain #(
	parameter int MAX_POINTS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire chmc_pkg::coord_t point_x,
	input  wire chmc_pkg::coord_t point_y,
	input  wire logic             set_end,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output chmc_pkg::coord_t      hull_x,
	output chmc_pkg::coord_t      hull_y,
	output logic                  hull_end,
	output logic                  points_dropped
);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int SW = $clog2(2 * MAX_POINTS);
	localparam int TW = $clog2(2 * MAX_POINTS + 1);

	chmc_pkg::cmd_t cmd;
	chmc_pkg::sts_t sts;
	logic [CW-1:0] n;
	logic [IW-1:0] s_waddr, s_raddr;
	logic [SW-1:0] st_addr;

	chmc_ctrl #(.MAX_POINTS(MAX_POINTS), .CW(CW), .IW(IW), .SW(SW), .TW(TW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .set_end(set_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .n(n), .cmd(cmd),
		.s_waddr(s_waddr), .s_raddr(s_raddr), .st_addr(st_addr)
	);

	chmc_datapath #(.MAX_POINTS(MAX_POINTS), .CW(CW), .IW(IW), .SW(SW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.s_waddr(s_waddr), .s_raddr(s_raddr), .st_addr(st_addr),
		.in_x(point_x), .in_y(point_y),
		.sts(sts), .n_out(n),
		.hull_x(hull_x), .hull_y(hull_y), .hull_end(hull_end),
		.points_dropped(points_dropped)
	);
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for convex_hull_monotone_chain: point sets in, hull vertices checked
// against an in-bench monotone chain predictor; depends on chmc_pkg and the block
`default_nettype none
module tb_top;
	localparam int CAP = 32;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		chmc_pkg::coord_t x;
		chmc_pkg::coord_t y;
		logic   last;
		logic   dropped;
	} vertex_t;

	typedef struct {
		chmc_pkg::coord_t x;
		chmc_pkg::coord_t y;
		logic   last;
	} point_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	chmc_pkg::coord_t point_x;
	chmc_pkg::coord_t point_y;
	logic   set_end;
	logic   out_valid;
	logic   out_stall;
	chmc_pkg::coord_t hull_x;
	chmc_pkg::coord_t hull_y;
	logic   hull_end;
	logic   points_dropped;

	convex_hull_monotone_chain #(.MAX_POINTS(CAP)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .set_end(set_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.hull_x(hull_x), .hull_y(hull_y), .hull_end(hull_end),
		.points_dropped(points_dropped)
	);

	vertex_t hull_q[$];
	point_t  stim_q[$];
	chmc_pkg::coord_t set_x[$];
	chmc_pkg::coord_t set_y[$];
	logic    set_ovf;
	int      errors;
	int      idle_cycles;
	bit      stim_done;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic left_or_straight(chmc_pkg::coord_t ax, chmc_pkg::coord_t ay,
			chmc_pkg::coord_t bx, chmc_pkg::coord_t by,
			chmc_pkg::coord_t cx, chmc_pkg::coord_t cy);
		longint dx1, dy1, dx2, dy2;
		dx1 = longint'(bx) - longint'(ax);
		dy1 = longint'(by) - longint'(ay);
		dx2 = longint'(cx) - longint'(bx);
		dy2 = longint'(cy) - longint'(by);
		return (dx1 * dy2 - dx2 * dy1) >= 0;
	endfunction

	// record one accepted point; on set end queue the hull vertices
	task automatic predict_hull(chmc_pkg::coord_t x, chmc_pkg::coord_t y, logic last);
		chmc_pkg::coord_t sx[$];
		chmc_pkg::coord_t sy[$];
		int stk[$];
		int n, k, lower;
		chmc_pkg::coord_t tx, ty;
		vertex_t v;
		if (set_x.size() < CAP) begin
			set_x.insert(set_x.size(), x);
			set_y.insert(set_y.size(), y);
		end else begin
			set_ovf = 1;
		end
		if (!last) return;
		sx = set_x;
		sy = set_y;
		n = sx.size();
		for (int i = 1; i < n; i++) begin
			tx = sx[i];
			ty = sy[i];
			k = i;
			while (k > 0 && (tx < sx[k-1] || (tx == sx[k-1] && ty < sy[k-1]))) begin
				sx[k] = sx[k-1];
				sy[k] = sy[k-1];
				k--;
			end
			sx[k] = tx;
			sy[k] = ty;
		end
		k = 1;
		for (int i = 1; i < n; i++) begin
			if (sx[i] != sx[k-1] || sy[i] != sy[k-1]) begin
				sx[k] = sx[i];
				sy[k] = sy[i];
				k++;
			end
		end
		n = k;
		if (n == 1) begin
			stk.insert(stk.size(), 0);
		end else begin
			for (int i = 0; i < n; i++) begin
				while (stk.size() >= 2 && left_or_straight(sx[stk[$-1]], sy[stk[$-1]],
						sx[stk[$]], sy[stk[$]], sx[i], sy[i]))
					stk.delete(stk.size() - 1);
				stk.insert(stk.size(), i);
			end
			lower = stk.size();
			for (int i = n - 2; i >= 0; i--) begin
				while (stk.size() > lower && left_or_straight(sx[stk[$-1]], sy[stk[$-1]],
						sx[stk[$]], sy[stk[$]], sx[i], sy[i]))
					stk.delete(stk.size() - 1);
				stk.insert(stk.size(), i);
			end
			stk.delete(stk.size() - 1);
		end
		foreach (stk[i]) begin
			v.x = sx[stk[i]];
			v.y = sy[stk[i]];
			v.last = (i == stk.size() - 1);
			v.dropped = set_ovf;
			hull_q.insert(hull_q.size(), v);
		end
		set_x.delete();
		set_y.delete();
		set_ovf = 0;
	endtask

	task automatic add_point(int x, int y, bit last);
		point_t p;
		p.x = chmc_pkg::coord_t'(x);
		p.y = chmc_pkg::coord_t'(y);
		p.last = last;
		stim_q.insert(stim_q.size(), p);
	endtask

	function automatic int rnd_coord(int span);
		int r;
		r = $urandom_range(9);
		if (r == 0) return $urandom_range(1) ? 32767 : -32768;
		if (r < 4) return int'($urandom_range(2 * span)) - span;
		return int'(chmc_pkg::coord_t'($urandom));
	endfunction

	// directed table, then random sets
	task automatic build_stimulus();
		int n, kind, span, bx, by;
		add_point(5, 5, 1);
		add_point(-32768, -32768, 0); add_point(32767, 32767, 1);
		add_point(7, 7, 0); add_point(7, 7, 0); add_point(7, 7, 1);
		add_point(0, 0, 0); add_point(16, 16, 0); add_point(32, 32, 0); add_point(48, 48, 1);
		add_point(-32768, -32768, 0); add_point(32767, -32768, 0);
		add_point(32767, 32767, 0); add_point(-32768, 32767, 0);
		add_point(0, 0, 1);
		add_point(0, 0, 0); add_point(0, 10, 0); add_point(10, 0, 0); add_point(0, 10, 1);
		add_point(1, 2, 0); add_point(1, -2, 0); add_point(3, 0, 1);
		// overflow, including the point that carries the set end
		for (int i = 0; i < CAP + 3; i++)
			add_point(rnd_coord(200), rnd_coord(200), i == CAP + 2);
		while (stim_q.size() < 330) begin
			kind = $urandom_range(9);
			n = (kind == 0) ? $urandom_range(CAP + 4, CAP + 1) : $urandom_range(12, 1);
			span = $urandom_range(1) ? 8 : 3000;
			bx = $urandom_range(3) == 0 ? 1 : 0;
			by = $urandom_range(20) - 10;
			for (int i = 0; i < n; i++) begin
				if (kind == 1)
					add_point(i * bx, by + i, i == n - 1);
				else
					add_point(rnd_coord(span), rnd_coord(span), i == n - 1);
			end
		end
	endtask

	initial begin
		int burst;
		point_t p;
		arst_n = 0;
		in_valid = 0;
		point_x = '0;
		point_y = '0;
		set_end = 0;
		errors = 0;
		set_ovf = 0;
		stim_done = 0;
		build_stimulus();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		while (stim_q.size() > 0) begin
			burst = $urandom_range(12, 1);
			while (burst > 0 && stim_q.size() > 0) begin
				p = stim_q.pop_front();
				in_valid = 1;
				point_x = p.x;
				point_y = p.y;
				set_end = p.last;
				@(posedge clk);
				while (in_stall) @(posedge clk);
				predict_hull(p.x, p.y, p.last);
				@(negedge clk);
				burst--;
			end
			in_valid = 0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		in_valid = 0;
		stim_done = 1;
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int mode;
		out_stall = 0;
		@(posedge arst_n);
		repeat (150) @(negedge clk);
		out_stall = 1;
		repeat (600) @(negedge clk);
		forever begin
			mode = $urandom_range(2);
			for (int i = 0; i < 40; i++) begin
				out_stall = (mode == 0) ? 0 : (mode == 1) ? ($urandom_range(3) == 0)
					: ($urandom_range(3) != 0);
				@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (hull_q.size() == 0) begin
				$display("%0t: unexpected vertex x=%0d y=%0d", $time, hull_x, hull_y);
				errors++;
			end else begin
				e = hull_q.pop_front();
				if (hull_x !== e.x || hull_y !== e.y || hull_end !== e.last
						|| points_dropped !== e.dropped)
					$display("%0t: vertex mismatch exp x=%0d y=%0d end=%b drop=%b got x=%0d y=%0d end=%b drop=%b",
						$time, e.x, e.y, e.last, e.dropped, hull_x, hull_y, hull_end,
						points_dropped);
				if (hull_x !== e.x || hull_y !== e.y || hull_end !== e.last
						|| points_dropped !== e.dropped)
					errors++;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (stim_done && hull_q.size() == 0) begin
				repeat (300) @(posedge clk);
				if (errors == 0)
					$display("tb_top: done, clean");
				else
					$display("tb_top: done, errors");
				$finish;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
